FILE: src/utf8_stream_validator_core_defines.svh
// Assertion macros for the UTF-8 stream validator.
// Included by files that carry concurrent checks; needs a clk and rst in scope.
`ifndef UTF8_STREAM_VALIDATOR_CORE_DEFINES_SVH
`define UTF8_STREAM_VALIDATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define UTF8SV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define UTF8SV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/utf8sv_pkg.sv
// Shared types and constants for the UTF-8 stream validator.
// No dependencies; used by utf8sv_step and utf8_stream_validator_core.
`timescale 1ns / 1ps

package utf8sv_pkg;

  localparam int CpWidth = 21;

  // Status codes reported with each transaction
  localparam logic [1:0] STATUS_BUSY_OK  = 2'd0;
  localparam logic [1:0] STATUS_BUSY_ERR = 2'd1;
  localparam logic [1:0] STATUS_END_OK   = 2'd2;
  localparam logic [1:0] STATUS_END_BAD  = 2'd3;

  // Sequence length codes (length minus one)
  localparam logic [1:0] LEN_ONE   = 2'd0;
  localparam logic [1:0] LEN_TWO   = 2'd1;
  localparam logic [1:0] LEN_THREE = 2'd2;
  localparam logic [1:0] LEN_FOUR  = 2'd3;

  // Decoder state carried from byte to byte
  typedef struct packed {
    logic [1:0]         bytes_left;
    logic [1:0]         seq_len;
    logic [CpWidth-1:0] code_point;
    logic               error_seen;
  } state_t;

endpackage

FILE: src/utf8sv_step.sv
// Combinational next-state and status logic for one byte of the validator.
// Depends on utf8sv_pkg.
`timescale 1ns / 1ps

module utf8sv_step (
  input  utf8sv_pkg::state_t cur,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  output utf8sv_pkg::state_t nxt,
  output logic [1:0]         status
);

  // Range checks on a completed multi-byte code point
  function automatic logic point_ok(input logic [1:0] len_code,
                                    input logic [utf8sv_pkg::CpWidth-1:0] cp);
    logic ok;
    ok = 1'b1;
    if (len_code == utf8sv_pkg::LEN_TWO   && cp < 21'h00080) ok = 1'b0;
    if (len_code == utf8sv_pkg::LEN_THREE && cp < 21'h00800) ok = 1'b0;
    if (len_code == utf8sv_pkg::LEN_FOUR  && cp < 21'h10000) ok = 1'b0;
    if (cp >= 21'h0D800 && cp <= 21'h0DFFF) ok = 1'b0;
    if (cp > 21'h10FFFF) ok = 1'b0;
    return ok;
  endfunction

  utf8sv_pkg::state_t dec;
  logic [utf8sv_pkg::CpWidth-1:0] cp_shift;

  assign cp_shift = {cur.code_point[utf8sv_pkg::CpWidth-7:0], data_byte[5:0]};

  // Decode the byte against the current state
  always_comb begin
    dec = cur;
    if (!cur.error_seen) begin
      if (cur.bytes_left == 2'd0) begin
        unique case (data_byte) inside
          8'h00: begin
            dec.error_seen = 1'b1;
          end
          [8'h01:8'h7F]: begin
            dec.seq_len    = utf8sv_pkg::LEN_ONE;
            dec.code_point = {13'd0, data_byte};
          end
          [8'hC2:8'hDF]: begin
            dec.seq_len    = utf8sv_pkg::LEN_TWO;
            dec.bytes_left = 2'd1;
            dec.code_point = {16'd0, data_byte[4:0]};
          end
          [8'hE0:8'hEF]: begin
            dec.seq_len    = utf8sv_pkg::LEN_THREE;
            dec.bytes_left = 2'd2;
            dec.code_point = {17'd0, data_byte[3:0]};
          end
          [8'hF0:8'hF4]: begin
            dec.seq_len    = utf8sv_pkg::LEN_FOUR;
            dec.bytes_left = 2'd3;
            dec.code_point = {18'd0, data_byte[2:0]};
          end
          default: begin
            dec.error_seen = 1'b1;
          end
        endcase
      end else if (data_byte[7:6] != 2'b10) begin
        // not a continuation byte
        dec.error_seen = 1'b1;
        dec.bytes_left = 2'd0;
      end else begin
        dec.code_point = cp_shift;
        dec.bytes_left = cur.bytes_left - 2'd1;
        if (cur.bytes_left == 2'd1 && !point_ok(cur.seq_len, cp_shift)) begin
          dec.error_seen = 1'b1;
        end
      end
    end
  end

  // Status and end-of-string clear
  always_comb begin
    if (last_byte) begin
      status = (dec.error_seen || dec.bytes_left != 2'd0) ?
               utf8sv_pkg::STATUS_END_BAD : utf8sv_pkg::STATUS_END_OK;
      nxt    = '0;
    end else begin
      status = dec.error_seen ? utf8sv_pkg::STATUS_BUSY_ERR : utf8sv_pkg::STATUS_BUSY_OK;
      nxt    = dec;
    end
  end

endmodule

FILE: src/utf8_stream_validator_core.sv
// Strict UTF-8 validator for a byte stream, one byte per transaction.
// Depends on utf8sv_pkg, utf8sv_step and utf8_stream_validator_core_defines.svh.
//
// Each input byte (with a last-byte flag) produces one status transaction:
// busy/ok, busy/error, ended valid or ended invalid. The block accepts one
// byte every cycle while the output is not stalled; each byte passes the input
// register, then the result register, before its status is offered. The rate
// is set by the decoder state update, which completes as a byte moves from
// the input register to the result register. While the result is stalled
// the input register holds one more byte, then the input stalls. Errors are
// sticky until the last byte of a string, after which all decoder state
// clears.
`timescale 1ns / 1ps
`include "utf8_stream_validator_core_defines.svh"

module utf8_stream_validator_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] status
);

  logic               in_q_valid;
  logic [7:0]         byte_q;
  logic               last_q;
  logic               advance;
  logic               in_take;
  utf8sv_pkg::state_t state;
  utf8sv_pkg::state_t state_next;
  logic [1:0]         status_next;

  // Handshake: the result register frees the input register
  assign advance  = in_q_valid && (!out_valid || !out_stall);
  assign in_stall = in_q_valid && out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_take) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      byte_q <= data_byte;
      last_q <= last_byte;
    end
  end

  utf8sv_step u_step (
    .cur       (state),
    .data_byte (byte_q),
    .last_byte (last_q),
    .nxt       (state_next),
    .status    (status_next)
  );

  // Decoder state, updated as each byte moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status <= status_next;
    end
  end

  // Checks
  `UTF8SV_ASSERT_NOW(a_left_within_len, 1'b1, state.bytes_left <= state.seq_len,
                     "bytes_left exceeds sequence length")
  `UTF8SV_ASSERT_NEXT(a_clear_after_last, advance && last_q, state == '0,
                      "state not cleared after last byte")
  `UTF8SV_ASSERT_NEXT(a_error_sticky, advance && state.error_seen && !last_q,
                      state.error_seen, "error flag dropped mid-string")
  `UTF8SV_ASSERT_NEXT(a_error_reported, advance && state.error_seen,
                      out_valid && (status == utf8sv_pkg::STATUS_BUSY_ERR ||
                                    status == utf8sv_pkg::STATUS_END_BAD),
                      "error not reported in status")

endmodule
